// ===== hw/rtl/tccc_pkg.sv =====
package tccc_pkg;

    // cube and field widths
    localparam int CUBE_BITS         = 32;
    localparam int VAR_COUNT_BITS    = 6;
    localparam int COUNT_BITS        = 6;
    localparam int VAR_WIDTH_DEFAULT = 32;

    // reset value of the variable count
    localparam logic [VAR_COUNT_BITS-1:0] VAR_COUNT_RESET = VAR_COUNT_BITS'(32);

    // population count masks
    localparam logic [CUBE_BITS-1:0] POP_M1  = 32'h5555_5555;
    localparam logic [CUBE_BITS-1:0] POP_M2  = 32'h3333_3333;
    localparam logic [CUBE_BITS-1:0] POP_M4  = 32'h0F0F_0F0F;
    localparam logic [CUBE_BITS-1:0] POP_M8  = 32'h00FF_00FF;
    localparam logic [CUBE_BITS-1:0] POP_M16 = 32'h0000_FFFF;

    // one cube pair
    typedef struct packed {
        logic [CUBE_BITS-1:0] cube_a_value;
        logic [CUBE_BITS-1:0] cube_a_dc;
        logic [CUBE_BITS-1:0] cube_b_value;
        logic [CUBE_BITS-1:0] cube_b_dc;
    } tccc_req_t;

    // comparison, consensus and separator of one pair
    typedef struct packed {
        logic                  a_absorbs_b;
        logic                  a_equals_b;
        logic [COUNT_BITS-1:0] conflict_count;
        logic                  orthogonal;
        logic                  adjacent;
        logic [CUBE_BITS-1:0]  consensus_value;
        logic [CUBE_BITS-1:0]  consensus_dc;
        logic [CUBE_BITS-1:0]  separator_value;
        logic                  separator_empty;
    } tccc_res_t;

    // positions in use, the count saturating at the variable width
    function automatic logic [CUBE_BITS-1:0] live_mask(
        input logic [VAR_COUNT_BITS-1:0] n,
        input int                        var_width
    );
        logic [CUBE_BITS-1:0] m;
        for (int i = 0; i < CUBE_BITS; i++)
        begin
            m[i] = (i < int'(n)) && (i < var_width);
        end
        return m;
    endfunction

    // five-level adder tree over bit fields
    function automatic logic [COUNT_BITS-1:0] count_ones(input logic [CUBE_BITS-1:0] v);
        logic [CUBE_BITS-1:0] x;
        x = (v & POP_M1) + ((v >> 1) & POP_M1);
        x = (x & POP_M2) + ((x >> 2) & POP_M2);
        x = (x & POP_M4) + ((x >> 4) & POP_M4);
        x = (x & POP_M8) + ((x >> 8) & POP_M8);
        x = (x & POP_M16) + ((x >> 16) & POP_M16);
        return x[COUNT_BITS-1:0];
    endfunction

endpackage

// ===== hw/rtl/tccc_core.sv =====
module tccc_core (
    input  tccc_pkg::tccc_req_t              req,
    input  logic [tccc_pkg::CUBE_BITS-1:0]   mask,
    output tccc_pkg::tccc_res_t              res
);
    import tccc_pkg::*;

    logic [CUBE_BITS-1:0]  av;
    logic [CUBE_BITS-1:0]  ad;
    logic [CUBE_BITS-1:0]  bv;
    logic [CUBE_BITS-1:0]  bd;
    logic [CUBE_BITS-1:0]  both_dc;
    logic [CUBE_BITS-1:0]  conflict;
    logic [COUNT_BITS-1:0] cnt;

    // drop positions beyond the variable count
    assign av = req.cube_a_value & mask;
    assign ad = req.cube_a_dc & mask;
    assign bv = req.cube_b_value & mask;
    assign bd = req.cube_b_dc & mask;

    // positions free in both, and positions defined in both that differ
    assign both_dc  = ad & bd;
    assign conflict = (av ^ bv) & ~ad & ~bd & mask;
    assign cnt      = count_ones(conflict);

    // assemble the result
    always_comb
    begin
        res.a_absorbs_b     = (both_dc == bd) && ((bv & ~ad & mask) == av);
        res.a_equals_b      = (av == bv) && (ad == bd);
        res.conflict_count  = cnt;
        res.orthogonal      = (cnt != '0);
        res.adjacent        = (cnt == COUNT_BITS'(1));
        res.consensus_value = (av | bv) & ~both_dc & ~conflict & mask;
        res.consensus_dc    = (both_dc | conflict) & mask;
        res.separator_value = conflict;
        res.separator_empty = (conflict == '0);
    end

endmodule

// ===== hw/rtl/ternary_cube_compare_consensus.sv =====
// Ternary cube comparison and consensus unit.
// Request channel: req_valid / req_ready carry one cube pair (req), value
// and don't-care vectors of A and B. Result channel: res_valid / res_ready
// carry absorb and equal flags, the conflict count with orthogonal and
// adjacent flags, the consensus cube and the separator cube with its
// empty flag.
// cfg_we writes cfg_data as the variable count; positions at or above it
// (saturating at VAR_WIDTH) are ignored. Write it only while the unit is
// empty.
// A request is taken into the input register; the masking, compare and
// population count logic then feeds the result register. Throughput is
// one pair per cycle while res_ready stays high, set by that single pass.
// A stalled receiver holds the result register; one more request is taken
// into the input register, after which req_ready drops until res_ready
// returns.
// Reset empties both registers and sets the variable count to 32.
module ternary_cube_compare_consensus #(
    parameter int VAR_WIDTH = tccc_pkg::VAR_WIDTH_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [tccc_pkg::VAR_COUNT_BITS-1:0]  cfg_data,
    input  logic                                 req_valid,
    output logic                                 req_ready,
    input  tccc_pkg::tccc_req_t                  req,
    output logic                                 res_valid,
    input  logic                                 res_ready,
    output tccc_pkg::tccc_res_t                  res
);
    import tccc_pkg::*;

    logic [CUBE_BITS-1:0] mask_reg;
    logic [CUBE_BITS-1:0] mask_next;
    logic                 stage_valid_reg;
    logic                 stage_valid_next;
    tccc_req_t            stage_req_reg;
    logic                 res_valid_reg;
    logic                 res_valid_next;
    tccc_res_t            res_reg;
    tccc_res_t            core_res;
    logic                 stage_advance;
    logic                 req_take;

    // handshake between the two registers
    assign stage_advance = !res_valid_reg || res_ready;
    assign req_ready     = !stage_valid_reg || stage_advance;
    assign req_take      = req_valid && req_ready;

    // variable mask, worked out once at each write
    assign mask_next = cfg_we ? live_mask(cfg_data, VAR_WIDTH) : mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= live_mask(VAR_COUNT_RESET, VAR_WIDTH);
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    // valid flags of the input and result registers
    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        res_valid_next   = res_valid_reg;
        if (stage_advance)
        begin
            res_valid_next = stage_valid_reg;
        end
        if (req_ready)
        begin
            stage_valid_next = req_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            stage_req_reg <= req;
        end
    end

    // compare and consensus logic
    tccc_core u_core (
        .req  (stage_req_reg),
        .mask (mask_reg),
        .res  (core_res)
    );

    // result register
    always_ff @(posedge clk)
    begin
        if (stage_advance && stage_valid_reg)
        begin
            res_reg <= core_res;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== hw/rtl/tccc_checker.sv =====
module tccc_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 req_valid,
    input logic                                 req_ready,
    input logic                                 res_valid,
    input logic                                 res_ready,
    input tccc_pkg::tccc_res_t                  res
);
    import tccc_pkg::*;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result changed while stalled");

    // every accepted request shows up as a result behind the input and result registers
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |-> ##2 res_valid)
    else $error("result missing two cycles after request");

    // requests are refused only behind a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> res_valid && !res_ready)
    else $error("request refused without a stall");

    // flags agree with the conflict count
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.orthogonal == (res.conflict_count != '0))
            && (res.adjacent == (res.conflict_count == COUNT_BITS'(1)))
            && (res.separator_empty == !res.orthogonal))
    else $error("result flags inconsistent");

endmodule

bind ternary_cube_compare_consensus tccc_checker u_tccc_checker (.*);

// ===== tb/ternary_cube_compare_consensus_tb.sv =====
`timescale 1ns / 100ps

module ternary_cube_compare_consensus_tb;

    import tccc_pkg::*;

    localparam int CYCLE_LIMIT = 100000;
    localparam int HOLD_CYCLES = 80;

    logic                      clk;
    logic                      rst_n     = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic [VAR_COUNT_BITS-1:0] cfg_data  = '0;
    logic                      req_valid = 1'b0;
    logic                      req_ready;
    tccc_req_t                 req       = '0;
    logic                      res_valid;
    logic                      res_ready = 1'b0;
    tccc_res_t                 res;

    // pairs waiting to be offered, and results predicted for accepted pairs
    tccc_req_t pending_pairs[$];
    tccc_res_t expected_results[$];

    logic [VAR_COUNT_BITS-1:0] var_count_model = VAR_COUNT_RESET;
    logic                      no_idle         = 1'b0;
    int                        mismatches      = 0;
    int                        results_seen    = 0;
    int                        hold_left       = 0;
    bit                        pressure_done   = 1'b0;
    int                        cycles          = 0;
    tccc_res_t                 oldest;

    ternary_cube_compare_consensus dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // comparison, consensus and separator of one pair under a variable count
    function automatic tccc_res_t predict_pair(tccc_req_t p, logic [VAR_COUNT_BITS-1:0] nvars);
        logic [CUBE_BITS-1:0] m;
        logic [CUBE_BITS-1:0] av;
        logic [CUBE_BITS-1:0] ad;
        logic [CUBE_BITS-1:0] bv;
        logic [CUBE_BITS-1:0] bd;
        logic [CUBE_BITS-1:0] both_dc;
        logic [CUBE_BITS-1:0] clash;
        int                   n;
        int                   cnt;
        tccc_res_t            r;
        n = (int'(nvars) > 32) ? 32 : int'(nvars);
        m = (n == 32) ? '1 : ((32'h1 << n) - 32'h1);
        av = p.cube_a_value & m;
        ad = p.cube_a_dc & m;
        bv = p.cube_b_value & m;
        bd = p.cube_b_dc & m;
        both_dc = ad & bd;
        clash = (av ^ bv) & ~ad & ~bd & m;
        cnt = 0;
        for (int i = 0; i < CUBE_BITS; i++)
        begin
            cnt += int'(clash[i]);
        end
        r.a_absorbs_b     = (both_dc == bd) && ((bv & ~ad & m) == av);
        r.a_equals_b      = (av == bv) && (ad == bd);
        r.conflict_count  = COUNT_BITS'(cnt);
        r.orthogonal      = (cnt >= 1);
        r.adjacent        = (cnt == 1);
        r.consensus_value = (av | bv) & ~both_dc & ~clash & m;
        r.consensus_dc    = (both_dc | clash) & m;
        r.separator_value = clash;
        r.separator_empty = (clash == '0);
        return r;
    endfunction

    function automatic tccc_req_t make_pair(logic [31:0] av, logic [31:0] ad,
                                            logic [31:0] bv, logic [31:0] bd);
        tccc_req_t p;
        p.cube_a_value = av;
        p.cube_a_dc    = ad;
        p.cube_b_value = bv;
        p.cube_b_dc    = bd;
        return p;
    endfunction

    // append one pair to the waiting list
    task automatic add_pair(tccc_req_t p);
        pending_pairs = {pending_pairs, p};
    endtask

    // mostly clean cubes, B derived from A in half the cases or drawn on its own, some raw noise
    function automatic tccc_req_t random_pair();
        logic [31:0] ad;
        logic [31:0] av;
        logic [31:0] bd;
        logic [31:0] bv;
        int          mode;
        mode = $urandom_range(9);
        case ($urandom_range(2))
            0:       ad = $urandom() & $urandom();
            1:       ad = $urandom() | $urandom();
            default: ad = $urandom();
        endcase
        av = $urandom() & ~ad;
        bd = ad;
        bv = av;
        case (mode)
            0, 1:
            begin
                av = $urandom();
                ad = $urandom();
                bv = $urandom();
                bd = $urandom();
            end
            2: ;
            3:
            begin
                // B narrower than A, so A absorbs it
                bd = ad & $urandom();
                bv = av | ($urandom() & ad & ~bd);
            end
            4: bv = (av ^ (32'h1 << $urandom_range(31))) & ~ad;
            5: bv = (av ^ ($urandom() & $urandom() & $urandom())) & ~ad;
            9: bv = av | ($urandom() & ad);
            default:
            begin
                bd = $urandom() & $urandom();
                bv = $urandom() & ~bd;
            end
        endcase
        return make_pair(av, ad, bv, bd);
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic wait_drained();
        while (pending_pairs.size() != 0 || req_valid || expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (3) @(posedge clk);
    endtask

    task automatic write_var_count(logic [VAR_COUNT_BITS-1:0] v);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        var_count_model = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                expected_results = {expected_results, predict_pair(req, var_count_model)};
            end
            if (!req_valid || req_ready)
            begin
                if (pending_pairs.size() != 0 && (no_idle || $urandom_range(99) >= 10))
                begin
                    req       <= pending_pairs.pop_front();
                    req_valid <= 1'b1;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random stalls and one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_ready <= 1'b0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("result with no pair outstanding");
                    mismatches++;
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    check_field("a_absorbs_b", 32'(oldest.a_absorbs_b),
                                32'(res.a_absorbs_b));
                    check_field("a_equals_b", 32'(oldest.a_equals_b),
                                32'(res.a_equals_b));
                    check_field("conflict_count", 32'(oldest.conflict_count),
                                32'(res.conflict_count));
                    check_field("orthogonal", 32'(oldest.orthogonal),
                                32'(res.orthogonal));
                    check_field("adjacent", 32'(oldest.adjacent), 32'(res.adjacent));
                    check_field("consensus_value", oldest.consensus_value,
                                res.consensus_value);
                    check_field("consensus_dc", oldest.consensus_dc, res.consensus_dc);
                    check_field("separator_value", oldest.separator_value,
                                res.separator_value);
                    check_field("separator_empty", 32'(oldest.separator_empty),
                                32'(res.separator_empty));
                end
            end
            if (hold_left != 0)
            begin
                hold_left--;
                res_ready <= 1'b0;
            end
            else if (!pressure_done && results_seen >= 100)
            begin
                pressure_done = 1'b1;
                hold_left = HOLD_CYCLES;
                res_ready <= 1'b0;
            end
            else
            begin
                res_ready <= no_idle || ($urandom_range(99) >= 10);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // stimulus phases over several variable counts
    initial
    begin
        logic [VAR_COUNT_BITS-1:0] settings[7];
        settings = '{6'd1, 6'd0, 6'd63, 6'd33, 6'd5, 6'd31, 6'd32};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed pairs at the reset count of 32
        add_pair(make_pair(32'h0, 32'h0, 32'h0, 32'h0));
        add_pair(make_pair('1, '1, '1, '1));
        add_pair(make_pair('1, 32'h0, 32'h0, 32'h0));
        add_pair(make_pair(32'h0, '1, 32'h1234_5600, 32'h0000_00FF));
        add_pair(make_pair(32'h0F0F_0000, 32'h0000_FFFF, 32'h0, '1));
        add_pair(make_pair(32'h0A50_0281, 32'h50A0_1400, 32'h0A50_0281,
                           32'h50A0_1400));
        add_pair(make_pair(32'h0000_0001, 32'h0, 32'h0, 32'h0));
        add_pair(make_pair(32'h8000_0000, 32'h0, 32'h0, 32'h0));
        add_pair(make_pair(32'h0, 32'h0, 32'h8000_0000, 32'h0));
        add_pair(make_pair(32'h0000_0001, 32'h0, 32'h0, 32'h0000_0001));
        // value bits under a don't-care
        add_pair(make_pair('1, '1, 32'h0, 32'h0));
        add_pair(make_pair(32'h0, 32'h0, 32'hFFFF_0000, 32'hFFFF_0000));
        add_pair(make_pair(32'h5555_5555, 32'h0, 32'hAAAA_AAAA, 32'h0));
        add_pair(make_pair(32'hAAAA_AAAA, 32'h5555_5555, 32'h0, 32'hFFFF_0000));
        add_pair(make_pair(32'h0000_0003, 32'h0, 32'h0, 32'h0));
        add_pair(make_pair(32'h0000_00F0, 32'h0000_000F, 32'h0000_00F0,
                           32'h0000_0000));
        add_pair(make_pair(32'h0000_00F0, 32'h0000_0000, 32'h0000_00F0,
                           32'h0000_000F));
        add_pair(make_pair(32'hFFFF_FFFE, 32'h0, 32'hFFFF_FFFF, 32'h0));
        add_pair(make_pair(32'h0, 32'hFFFF_FFFE, 32'h1, 32'hFFFF_FFFE));
        add_pair(make_pair(32'h0, 32'hFFFF_FFFE, 32'h1, 32'h0));
        repeat (200) add_pair(random_pair());

        foreach (settings[i])
        begin
            wait_drained();
            no_idle = (i == 3);
            write_var_count(settings[i]);
            @(negedge clk);
            add_pair(make_pair('1, 32'h0, 32'h0, 32'h0));
            add_pair(make_pair(32'h0, '1, '1, 32'h0));
            repeat (32) add_pair(random_pair());
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
